// ----- rtl/atl_pkg.sv -----
// Shared types and constants of the arithmetic token lexer.
// Used by atl_scan and arith_token_lexer_unit; depends on nothing.
package atl_pkg;

    localparam int VALUE_WIDTH_DEF    = 32;
    localparam int POSITION_WIDTH_DEF = 16;

    localparam int TOK_VALUE_W = 32;
    localparam int TOK_POS_W   = 16;

    localparam logic [2:0] KIND_INT     = 3'd0;
    localparam logic [2:0] KIND_PLUS    = 3'd1;
    localparam logic [2:0] KIND_MINUS   = 3'd2;
    localparam logic [2:0] KIND_STAR    = 3'd3;
    localparam logic [2:0] KIND_SLASH   = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN = 3'd6;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [2:0]             kind;
        logic [TOK_VALUE_W-1:0] value;
        logic [TOK_POS_W-1:0]   line;
        logic [TOK_POS_W-1:0]   col;
        logic                   ovf;
        logic                   last;
    } t_token;

endpackage

// ----- rtl/arith_token_lexer_unit.sv -----
// Top level of the arithmetic token lexer: input register, atl_scan, two-entry token buffer.
// Depends on atl_pkg and atl_scan.
//
// channel  dir  tdata                          tuser              tlast
// s_axis   in   [7:0] char_code                end_of_input       -
// m_axis   out  [31:0] value [47:32] line      [2:0] kind         last token of
//                [63:48] column                [3] value_overflow the input item
//
// A transaction accepted into the input register is decoded combinationally from it;
// its tokens enter the two-entry buffer once they fit and leave from the buffer head.
// One character per cycle is sustained while each yields at most one token and the
// output is ready; a transaction that yields two (number plus terminator) needs two free entries.
// The input stalls when the decoded tokens do not fit the buffer; s_axis_tready depends
// combinationally on m_axis_tready. Reset is synchronous, active low; no clearing pass.
module arith_token_lexer_unit #(
    parameter int VALUE_WIDTH    = atl_pkg::VALUE_WIDTH_DEF,
    parameter int POSITION_WIDTH = atl_pkg::POSITION_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tuser,   // [0] end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] token_value, [47:32] line_at, [63:48] column_at
    output logic [3:0]  m_axis_tuser,   // [2:0] token_kind, [3] value_overflow
    output logic        m_axis_tlast    // last_of_run
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_end;

    atl_pkg::t_token r_tok0, r_tok1, n_tok0, n_tok1;
    logic [1:0]      r_cnt, n_cnt;

    atl_pkg::t_token new_tok0, new_tok1;
    logic [1:0]      new_count;
    logic            pop, proc_fire;
    logic [1:0]      remain, space;
    atl_pkg::t_token head;

    atl_scan #(
        .VALUE_WIDTH    (VALUE_WIDTH),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (proc_fire),
        .i_char  (r_in_char),
        .i_end   (r_in_end),
        .o_tok0  (new_tok0),
        .o_tok1  (new_tok1),
        .o_count (new_count)
    );

    assign pop       = m_axis_tvalid && m_axis_tready;
    assign remain    = r_cnt - {1'b0, pop};
    assign space     = 2'd2 - remain;
    assign proc_fire = r_in_valid && (new_count <= space);
    assign head      = pop ? r_tok1 : r_tok0;

    assign s_axis_tready = i_rst_n && (!r_in_valid || proc_fire);

    always_comb begin
        n_cnt  = remain + (proc_fire ? new_count : 2'd0);
        n_tok0 = head;
        n_tok1 = r_tok1;
        case (remain)
            2'd0: begin
                n_tok0 = new_tok0;
                n_tok1 = new_tok1;
            end
            2'd1: begin
                n_tok1 = new_tok0;
            end
            default: begin
                n_tok1 = r_tok1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_end  <= s_axis_tuser;
        end
        r_tok0 <= n_tok0;
        r_tok1 <= n_tok1;
    end

    assign m_axis_tvalid = r_cnt != 2'd0;
    assign m_axis_tdata  = {r_tok0.col, r_tok0.line, r_tok0.value};
    assign m_axis_tuser  = {r_tok0.ovf, r_tok0.kind};
    assign m_axis_tlast  = r_tok0.last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("token buffer count out of range");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 && !pop && proc_fire |-> new_count == 2'd0)
        else $error("decode fired tokens into a full token buffer");

    a_ovf_only_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_tok0.kind != atl_pkg::KIND_INT |-> !r_tok0.ovf)
        else $error("overflow flag on a non-integer token");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled token transaction changed");

endmodule

// ----- rtl/atl_scan.sv -----
// Lexer state (number accumulator, line and column) and token decode for one character.
// Depends on atl_pkg.
module atl_scan #(
    parameter int VALUE_WIDTH    = atl_pkg::VALUE_WIDTH_DEF,
    parameter int POSITION_WIDTH = atl_pkg::POSITION_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_char,
    input  logic            i_end,
    output atl_pkg::t_token o_tok0,
    output atl_pkg::t_token o_tok1,
    output logic [1:0]      o_count
);

    localparam int VW = VALUE_WIDTH;
    localparam int PW = POSITION_WIDTH;

    logic          r_in_number, n_in_number;
    logic [VW-1:0] r_acc, n_acc;
    logic          r_ovf, n_ovf;
    logic [PW-1:0] r_line, n_line;
    logic [PW-1:0] r_col, n_col;

    logic            is_digit, is_ws, flush, has_other;
    logic [3:0]      digit;
    logic [VW+3:0]   acc_wide, prod;
    logic [PW+15:0]  line_ext, col_ext;
    logic [VW+31:0]  acc_ext;
    logic [2:0]      other_kind;
    logic [31:0]     other_value;
    atl_pkg::t_token tok_int, tok_other;

    assign is_digit = i_char inside {[atl_pkg::CH_ZERO:atl_pkg::CH_NINE]};
    assign is_ws    = i_char inside {atl_pkg::CH_SPACE, atl_pkg::CH_TAB, atl_pkg::CH_LF,
                                     atl_pkg::CH_CR, atl_pkg::CH_FF};
    assign digit    = i_char[3:0];
    assign acc_wide = {4'b0, r_acc};
    assign prod     = (acc_wide << 3) + (acc_wide << 1) + {{VW{1'b0}}, digit};

    always_comb begin
        n_in_number = r_in_number;
        n_acc       = r_acc;
        n_ovf       = r_ovf;
        n_line      = r_line;
        n_col       = r_col;
        if (i_end) begin
            n_in_number = 1'b0;
            n_acc       = '0;
            n_ovf       = 1'b0;
        end else begin
            if (r_col != {PW{1'b1}}) begin
                n_col = r_col + {{(PW-1){1'b0}}, 1'b1};
            end
            if (i_char == atl_pkg::CH_LF) begin
                n_col = '0;
                if (r_line != {PW{1'b1}}) begin
                    n_line = r_line + {{(PW-1){1'b0}}, 1'b1};
                end
            end
            if (is_digit) begin
                n_in_number = 1'b1;
                if (!r_in_number) begin
                    n_acc = {{(VW-4){1'b0}}, digit};
                    n_ovf = 1'b0;
                end else if (prod[VW+3:VW] != 4'd0) begin
                    n_acc = {VW{1'b1}};
                    n_ovf = 1'b1;
                end else begin
                    n_acc = prod[VW-1:0];
                end
            end else begin
                n_in_number = 1'b0;
                n_acc       = '0;
                n_ovf       = 1'b0;
            end
        end
    end

    // Tokens carry the position after this character.
    assign line_ext = {16'b0, n_line};
    assign col_ext  = {16'b0, n_col};
    assign acc_ext  = {32'b0, r_acc};

    always_comb begin
        has_other   = 1'b1;
        other_kind  = atl_pkg::KIND_UNKNOWN;
        other_value = {24'b0, i_char};
        if (i_end) begin
            other_kind  = atl_pkg::KIND_END;
            other_value = '0;
        end else if (is_digit || is_ws) begin
            has_other   = 1'b0;
            other_value = '0;
        end else begin
            case (i_char)
                atl_pkg::CH_PLUS:  begin other_kind = atl_pkg::KIND_PLUS;  other_value = '0; end
                atl_pkg::CH_MINUS: begin other_kind = atl_pkg::KIND_MINUS; other_value = '0; end
                atl_pkg::CH_STAR:  begin other_kind = atl_pkg::KIND_STAR;  other_value = '0; end
                atl_pkg::CH_SLASH: begin other_kind = atl_pkg::KIND_SLASH; other_value = '0; end
                default: begin
                    other_kind  = atl_pkg::KIND_UNKNOWN;
                    other_value = {24'b0, i_char};
                end
            endcase
        end
    end

    assign flush = r_in_number && (i_end || !is_digit);

    always_comb begin
        tok_int.kind  = atl_pkg::KIND_INT;
        tok_int.value = acc_ext[31:0];
        tok_int.line  = line_ext[15:0];
        tok_int.col   = col_ext[15:0];
        tok_int.ovf   = r_ovf;
        tok_int.last  = !has_other;

        tok_other.kind  = other_kind;
        tok_other.value = other_value;
        tok_other.line  = line_ext[15:0];
        tok_other.col   = col_ext[15:0];
        tok_other.ovf   = 1'b0;
        tok_other.last  = 1'b1;
    end

    assign o_tok0  = flush ? tok_int : tok_other;
    assign o_tok1  = tok_other;
    assign o_count = {1'b0, flush} + {1'b0, has_other};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_number <= 1'b0;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_line      <= {{(PW-1){1'b0}}, 1'b1};
            r_col       <= '0;
        end else if (i_step) begin
            r_in_number <= n_in_number;
            r_acc       <= n_acc;
            r_ovf       <= n_ovf;
            r_line      <= n_line;
            r_col       <= n_col;
        end
    end

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line count reached zero");

    a_end_clears_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_end |=> !r_in_number && !r_ovf)
        else $error("number state survived end of input");

    a_newline_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_end && i_char == atl_pkg::CH_LF |=> r_col == '0)
        else $error("newline did not clear column");

    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_acc == {VW{1'b1}} && r_in_number)
        else $error("overflow flag without saturated value");

endmodule

// ----- test/tb_arith_token_lexer_unit.sv -----
// Testbench for arith_token_lexer_unit: streams characters and end marks in, predicts the
// tokens with a behavioral lexer of its own and checks every output transaction in order.
// Depends on atl_pkg and the lexer RTL.
`timescale 1ns / 100ps

module tb_arith_token_lexer_unit;

    localparam int          CLK_PERIOD  = 10;
    localparam int          RST_CYCLES  = 6;
    localparam int          RAND_ITEMS  = 625;
    localparam int          HOLD_AT     = 60;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN       = 20;
    localparam logic [31:0] VALUE_MAX   = 32'hFFFF_FFFF;
    localparam logic [15:0] POS_MAX     = 16'hFFFF;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
    } t_char_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] char_code
    logic        s_axis_tuser = 1'b0; // [0] end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // [31:0] token_value, [47:32] line_at, [63:48] column_at
    logic [3:0]  m_axis_tuser;        // [2:0] token_kind, [3] value_overflow
    logic        m_axis_tlast;

    t_char_item      chars_pending[$];
    atl_pkg::t_token tokens_due[$];

    // lexer state mirrored by the predictor
    logic        lex_in_num = 1'b0;
    logic [31:0] lex_acc = '0;
    logic        lex_ovf = 1'b0;
    logic [15:0] lex_line = 16'd1;
    logic [15:0] lex_col = '0;

    int     mismatches = 0;
    int     tokens_seen = 0;
    int     feed_gap = 0;
    int     feed_burst = 0;
    int     drain_gap = 0;
    int     drain_burst = 0;
    int     hold_left = 0;
    longint cycle_count = 0;
    longint cycle_limit = 0;

    arith_token_lexer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic atl_pkg::t_token make_token(logic [2:0] kind, logic [31:0] value,
                                                   logic ovf);
        atl_pkg::t_token tok;
        tok.kind  = kind;
        tok.value = value;
        tok.line  = lex_line;
        tok.col   = lex_col;
        tok.ovf   = ovf;
        tok.last  = 1'b0;
        return tok;
    endfunction

    function automatic atl_pkg::t_token take_number();
        atl_pkg::t_token tok;
        tok        = make_token(atl_pkg::KIND_INT, lex_acc, lex_ovf);
        lex_in_num = 1'b0;
        lex_acc    = '0;
        lex_ovf    = 1'b0;
        return tok;
    endfunction

    // Advance the lexer by one input transaction and queue the tokens it yields.
    function automatic void lex_predict(logic [7:0] ch, logic eoi);
        atl_pkg::t_token toks[2];
        int              n;
        logic [63:0]     d;
        n = 0;
        if (eoi) begin
            if (lex_in_num) toks[n++] = take_number();
            toks[n++] = make_token(atl_pkg::KIND_END, '0, 1'b0);
        end else begin
            if (lex_col != POS_MAX) lex_col++;
            if (ch == atl_pkg::CH_LF) begin
                lex_col = '0;
                if (lex_line != POS_MAX) lex_line++;
            end
            if (ch >= atl_pkg::CH_ZERO && ch <= atl_pkg::CH_NINE) begin
                d = 64'(ch - atl_pkg::CH_ZERO);
                if (!lex_in_num) begin
                    lex_in_num = 1'b1;
                    lex_acc    = d[31:0];
                    lex_ovf    = 1'b0;
                end else if (64'(lex_acc) > (64'(VALUE_MAX) - d) / 10) begin
                    lex_acc = VALUE_MAX;
                    lex_ovf = 1'b1;
                end else begin
                    lex_acc = lex_acc * 32'd10 + d[31:0];
                end
            end else begin
                if (lex_in_num) toks[n++] = take_number();
                case (ch)
                    atl_pkg::CH_SPACE, atl_pkg::CH_TAB, atl_pkg::CH_LF,
                    atl_pkg::CH_CR, atl_pkg::CH_FF: ;
                    atl_pkg::CH_PLUS:  toks[n++] = make_token(atl_pkg::KIND_PLUS, '0, 1'b0);
                    atl_pkg::CH_MINUS: toks[n++] = make_token(atl_pkg::KIND_MINUS, '0, 1'b0);
                    atl_pkg::CH_STAR:  toks[n++] = make_token(atl_pkg::KIND_STAR, '0, 1'b0);
                    atl_pkg::CH_SLASH: toks[n++] = make_token(atl_pkg::KIND_SLASH, '0, 1'b0);
                    default: toks[n++] = make_token(atl_pkg::KIND_UNKNOWN, 32'(ch), 1'b0);
                endcase
            end
        end
        if (n > 0) toks[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) tokens_due.push_back(toks[i]);
    endfunction

    task automatic push_char(logic [7:0] ch, logic eoi = 1'b0);
        t_char_item it;
        it.ch  = ch;
        it.eoi = eoi;
        chars_pending.push_back(it);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    task automatic push_digits(int count);
        for (int i = 0; i < count; i++)
            push_char(atl_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // source: drives characters out of the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                lex_predict(s_axis_tdata, s_axis_tuser);
                feed_gap = pick_gap(feed_burst);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (feed_gap == 0 && chars_pending.size() != 0) begin
                    t_char_item it;
                    it = chars_pending.pop_front();
                    s_axis_tdata  <= it.ch;
                    s_axis_tuser  <= it.eoi;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                    if (feed_gap > 0) feed_gap--;
                end
            end
        end
    end

    // sink: checks each token transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                atl_pkg::t_token want;
                if (tokens_due.size() == 0) begin
                    $error("unexpected token: kind %0d value %0d",
                           m_axis_tuser[2:0], m_axis_tdata[31:0]);
                    mismatches++;
                end else begin
                    want = tokens_due.pop_front();
                    if (m_axis_tuser[2:0] !== want.kind) begin
                        $error("token_kind: expected %0d, got %0d", want.kind, m_axis_tuser[2:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[31:0] !== want.value) begin
                        $error("token_value: expected %0d, got %0d",
                               want.value, m_axis_tdata[31:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[47:32] !== want.line) begin
                        $error("line_at: expected %0d, got %0d", want.line, m_axis_tdata[47:32]);
                        mismatches++;
                    end
                    if (m_axis_tdata[63:48] !== want.col) begin
                        $error("column_at: expected %0d, got %0d", want.col, m_axis_tdata[63:48]);
                        mismatches++;
                    end
                    if (m_axis_tuser[3] !== want.ovf) begin
                        $error("value_overflow: expected %0d, got %0d", want.ovf, m_axis_tuser[3]);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_of_run: expected %0d, got %0d", want.last, m_axis_tlast);
                        mismatches++;
                    end
                end
                tokens_seen++;
                drain_gap = pick_gap(drain_burst);
                if (tokens_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (drain_gap > 0) begin
                drain_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_limit != 0 && cycle_count > cycle_limit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int base;
        int pick;

        // directed: every operator, each whitespace, byte extremes, numbers cut by
        // operators, whitespace, unknown bytes and end marks
        push_text("7+12-*/");
        push_char(atl_pkg::CH_SPACE);
        push_char(atl_pkg::CH_TAB);
        push_char(atl_pkg::CH_CR);
        push_char(atl_pkg::CH_FF);
        push_char(atl_pkg::CH_LF);
        push_char(8'h00);
        push_char(8'hFF);
        push_text("09");
        push_char(8'h00, 1'b1);
        push_char(8'hA5, 1'b1);
        push_text("3A5");
        push_char(atl_pkg::CH_LF);
        push_char(8'h38);
        push_char(8'hFF, 1'b1);

        // random expressions with noise
        base = chars_pending.size();
        while (chars_pending.size() < base + RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) push_digits($urandom_range(1, 4));
                else if (pick < 95) push_digits($urandom_range(5, 9));
                else push_digits($urandom_range(11, 14));
            end else if (pick < 65) begin
                case ($urandom_range(0, 3))
                    0: push_char(atl_pkg::CH_PLUS);
                    1: push_char(atl_pkg::CH_MINUS);
                    2: push_char(atl_pkg::CH_STAR);
                    default: push_char(atl_pkg::CH_SLASH);
                endcase
            end else if (pick < 80) begin
                case ($urandom_range(0, 5))
                    0: push_char(atl_pkg::CH_SPACE);
                    1: push_char(atl_pkg::CH_TAB);
                    2: push_char(atl_pkg::CH_CR);
                    3: push_char(atl_pkg::CH_FF);
                    default: push_char(atl_pkg::CH_LF);
                endcase
            end else if (pick < 92) begin
                push_char(8'($urandom_range(0, 255)));
            end else if (pick < 96) begin
                push_char(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                case ($urandom_range(0, 2))
                    0: push_text("4294967295");
                    1: push_text("4294967296");
                    default: push_text("99999999999999");
                endcase
            end
        end
        push_char(8'h00, 1'b1);

        cycle_limit = 400 * longint'(chars_pending.size()) + 20000;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (chars_pending.size() != 0 || s_axis_tvalid || tokens_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);

        if (tokens_due.size() != 0) begin
            $error("%0d tokens never arrived", tokens_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
